@@ hw/rtl/stma_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stma_pkg
// Shared widths, codes and types of the sparse triplet matrix adder.
// ----------------------------------------------------------------------------
package stma_pkg;

    localparam int MAX_TERMS_DEF = 16;

    localparam int MODE_W  = 2;
    localparam int IDX_W   = 5;
    localparam int VAL_W   = 32;
    localparam int SUM_W   = 33;
    localparam int COUNT_W = 6;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MERGE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_CMP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_term;

    // decision of one merge step
    typedef struct packed {
        logic                    adv;
        logic                    done;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [SUM_W-1:0] value;
    } t_alu_res;

endpackage : stma_pkg
`default_nettype wire

@@ hw/rtl/stma_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stma_ifs
// Valid/ready channels for input terms and result terms.
// ----------------------------------------------------------------------------
interface stma_in_if;
    logic                                      valid;
    logic                                      ready;
    logic [stma_pkg::MODE_W-1:0]               mode;
    logic [stma_pkg::IDX_W-1:0]                term_row;
    logic [stma_pkg::IDX_W-1:0]                term_col;
    logic signed [stma_pkg::VAL_W-1:0]         term_value;

    modport source (output valid, mode, term_row, term_col, term_value, input ready);
    modport sink   (input valid, mode, term_row, term_col, term_value, output ready);
endinterface : stma_in_if

interface stma_out_if;
    logic                                      valid;
    logic                                      ready;
    logic [stma_pkg::IDX_W-1:0]                out_row;
    logic [stma_pkg::IDX_W-1:0]                out_col;
    logic signed [stma_pkg::SUM_W-1:0]         out_value;
    logic                                      is_end;
    logic [stma_pkg::COUNT_W-1:0]              term_count;
    logic                                      overflow;

    modport source (output valid, out_row, out_col, out_value, is_end, term_count,
                    overflow, input ready);
    modport sink   (input valid, out_row, out_col, out_value, is_end, term_count,
                    overflow, output ready);
endinterface : stma_out_if
`default_nettype wire

@@ hw/rtl/stma_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stma_store
// Term store for the first matrix: one write port, one registered read port.
// ----------------------------------------------------------------------------
module stma_store #(
    parameter int MAX_TERMS = stma_pkg::MAX_TERMS_DEF,
    parameter int ADDR_W    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_wr_en,
    input  wire logic [ADDR_W-1:0]   i_wr_addr,
    input  wire stma_pkg::t_term     i_wr_data,
    input  wire logic                i_rd_en,
    input  wire logic [ADDR_W-1:0]   i_rd_addr,
    output stma_pkg::t_term          o_rd_data
);

    stma_pkg::t_term r_mem [MAX_TERMS];
    stma_pkg::t_term r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule : stma_store
`default_nettype wire

@@ hw/rtl/stma_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stma_alu
// Shared compare and add unit: one merge step between a stored term and
// the current term.
// ----------------------------------------------------------------------------
module stma_alu (
    input  wire logic                i_have,
    input  wire logic                i_flush,
    input  wire stma_pkg::t_term     i_stored,
    input  wire stma_pkg::t_term     i_cur,
    output stma_pkg::t_alu_res       o_res
);

    logic                               row_eq;
    logic                               pos_lt;
    logic                               pos_eq;
    logic signed [stma_pkg::SUM_W-1:0]  stored_ext;
    logic signed [stma_pkg::SUM_W-1:0]  cur_ext;
    logic signed [stma_pkg::SUM_W-1:0]  sum;

    assign row_eq     = (i_stored.row == i_cur.row);
    assign pos_lt     = (i_stored.row < i_cur.row) || (row_eq && (i_stored.col < i_cur.col));
    assign pos_eq     = row_eq && (i_stored.col == i_cur.col);
    assign stored_ext = {i_stored.value[stma_pkg::VAL_W-1], i_stored.value};
    assign cur_ext    = {i_cur.value[stma_pkg::VAL_W-1], i_cur.value};
    assign sum        = stored_ext + cur_ext;

    always_comb begin
        priority if (!i_have) begin
            o_res.adv   = 1'b0;
            o_res.done  = 1'b1;
            o_res.row   = i_cur.row;
            o_res.col   = i_cur.col;
            o_res.value = cur_ext;
        end else if (i_flush || pos_lt) begin
            // stored term comes first
            o_res.adv   = 1'b1;
            o_res.done  = 1'b0;
            o_res.row   = i_stored.row;
            o_res.col   = i_stored.col;
            o_res.value = stored_ext;
        end else if (pos_eq) begin
            o_res.adv   = 1'b1;
            o_res.done  = 1'b1;
            o_res.row   = i_cur.row;
            o_res.col   = i_cur.col;
            o_res.value = sum;
        end else begin
            o_res.adv   = 1'b0;
            o_res.done  = 1'b1;
            o_res.row   = i_cur.row;
            o_res.col   = i_cur.col;
            o_res.value = cur_ext;
        end
    end

endmodule : stma_alu
`default_nettype wire

@@ hw/rtl/sparse_triplet_matrix_add.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_triplet_matrix_add
// Adds two sparse matrices given as row-major sorted triplets by merging.
// ----------------------------------------------------------------------------
// Load the first matrix with mode 0 items (accepted back to back; terms beyond
// MAX_TERMS are dropped and reported as overflow), then send the second
// matrix with mode 1 items and close with a mode 2 item, which flushes the
// remaining stored terms and ends with an end item carrying the term count.
// A merge or finish item holds the block until its last result is taken; each
// result passes through a store read, compare/add in the shared unit and the
// output register, where the output side may stall it. The input is not ready
// meanwhile. The read port of the term store is registered.
// After the end item all counters are back at zero for the next pair.
module sparse_triplet_matrix_add #(
    parameter int MAX_TERMS = stma_pkg::MAX_TERMS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    stma_in_if.sink      i_in,
    stma_out_if.source   o_out
);

    localparam int CNT_W  = $clog2(MAX_TERMS + 1);
    localparam int ADDR_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_TERMS);

    stma_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              r_rptr;
    logic [stma_pkg::COUNT_W-1:0]  r_emit;
    logic                          r_dropped;
    logic                          r_have;
    logic                          r_last;
    logic                          r_flush;
    stma_pkg::t_term               r_cur;

    logic                          r_out_valid;
    logic [stma_pkg::IDX_W-1:0]    r_out_row;
    logic [stma_pkg::IDX_W-1:0]    r_out_col;
    logic signed [stma_pkg::SUM_W-1:0] r_out_value;
    logic                          r_out_end;
    logic [stma_pkg::COUNT_W-1:0]  r_out_count;
    logic                          r_out_ovf;

    logic                          in_acc;
    logic                          out_acc;
    logic                          store_room;
    logic                          wr_en;
    logic                          rd_en;
    logic                          load_end;
    logic                          load_term;
    stma_pkg::t_term               in_term;
    stma_pkg::t_term               rd_data;
    stma_pkg::t_alu_res            alu_res;

    assign in_acc     = i_in.valid && i_in.ready;
    assign out_acc    = o_out.valid && o_out.ready;
    assign store_room = (r_count < CNT_FULL);
    assign in_term    = '{row: i_in.term_row, col: i_in.term_col, value: i_in.term_value};

    stma_store #(
        .MAX_TERMS (MAX_TERMS),
        .ADDR_W    (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (in_term),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rptr[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    stma_alu u_alu (
        .i_have   (r_have),
        .i_flush  (r_flush),
        .i_stored (rd_data),
        .i_cur    (r_cur),
        .o_res    (alu_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stma_pkg::S_IDLE: begin
                if (in_acc && (i_in.mode == stma_pkg::MODE_MERGE ||
                               i_in.mode == stma_pkg::MODE_FINISH)) begin
                    n_state = stma_pkg::S_FETCH;
                end
            end
            stma_pkg::S_FETCH: n_state = stma_pkg::S_CMP;
            stma_pkg::S_CMP:   n_state = stma_pkg::S_EMIT;
            stma_pkg::S_EMIT: begin
                if (out_acc) begin
                    n_state = r_last ? stma_pkg::S_IDLE : stma_pkg::S_FETCH;
                end
            end
            default: n_state = stma_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        i_in.ready = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        load_end   = 1'b0;
        load_term  = 1'b0;
        unique case (r_state)
            stma_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
                wr_en      = in_acc && (i_in.mode == stma_pkg::MODE_LOAD) && store_room;
            end
            stma_pkg::S_FETCH: rd_en = (r_rptr < r_count);
            stma_pkg::S_CMP: begin
                load_end  = r_flush && !r_have;
                load_term = !(r_flush && !r_have);
            end
            stma_pkg::S_EMIT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stma_pkg::S_IDLE;
            r_count     <= '0;
            r_rptr      <= '0;
            r_emit      <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (in_acc && (i_in.mode == stma_pkg::MODE_LOAD) && !store_room) begin
                r_dropped <= 1'b1;
            end
            if (load_term) begin
                if (r_emit != stma_pkg::COUNT_MAX) begin
                    r_emit <= r_emit + stma_pkg::COUNT_W'(1);
                end
                if (alu_res.adv) begin
                    r_rptr <= r_rptr + CNT_W'(1);
                end
            end
            // end item captured: start over for the next pair
            if (load_end) begin
                r_count   <= '0;
                r_rptr    <= '0;
                r_emit    <= '0;
                r_dropped <= 1'b0;
            end
            if (load_end || load_term) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cur   <= in_term;
            r_flush <= (i_in.mode == stma_pkg::MODE_FINISH);
        end
        if (r_state == stma_pkg::S_FETCH) begin
            r_have <= (r_rptr < r_count);
        end
        if (load_term) begin
            r_last      <= alu_res.done;
            r_out_row   <= alu_res.row;
            r_out_col   <= alu_res.col;
            r_out_value <= alu_res.value;
            r_out_end   <= 1'b0;
            r_out_count <= '0;
            r_out_ovf   <= 1'b0;
        end else if (load_end) begin
            r_last      <= 1'b1;
            r_out_row   <= '0;
            r_out_col   <= '0;
            r_out_value <= '0;
            r_out_end   <= 1'b1;
            r_out_count <= r_emit;
            r_out_ovf   <= r_dropped;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_row    = r_out_row;
    assign o_out.out_col    = r_out_col;
    assign o_out.out_value  = r_out_value;
    assign o_out.is_end     = r_out_end;
    assign o_out.term_count = r_out_count;
    assign o_out.overflow   = r_out_ovf;

`ifndef SYNTHESIS
    a_rptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rptr <= r_count)
        else $error("read pointer passed stored count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("stored count beyond capacity");

    a_valid_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == stma_pkg::S_EMIT))
        else $error("result shown outside emit state");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out.is_end) |=> (r_count == '0 && r_rptr == '0 && r_emit == '0
                                       && r_state == stma_pkg::S_IDLE))
        else $error("state not cleared after end item");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != stma_pkg::S_IDLE) |-> !i_in.ready)
        else $error("input taken while busy");
`endif

endmodule : sparse_triplet_matrix_add
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sparse triplet matrix adder. A queue of input
// items (directed corner cases, then random matrix pairs, scrambled lists and
// ignored items) feeds a valid/ready driver. Every accepted item runs through
// a merge predictor that builds the expected sum terms, and a monitor checks
// each result term field by field while both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TARGET_ITEMS    = 460;
    localparam int PRESSURE_CYCLES = 300;
    localparam int STALL_LIMIT     = 3000;
    localparam int DRAIN_CYCLES    = 60;
    localparam int POS_LIMIT       = 1024;

    typedef struct {
        logic [stma_pkg::MODE_W-1:0]       mode;
        logic [stma_pkg::IDX_W-1:0]        row;
        logic [stma_pkg::IDX_W-1:0]        col;
        logic signed [stma_pkg::VAL_W-1:0] value;
    } t_in_item;

    typedef struct {
        logic [stma_pkg::IDX_W-1:0]        row;
        logic [stma_pkg::IDX_W-1:0]        col;
        logic signed [stma_pkg::SUM_W-1:0] value;
        logic                              is_end;
        logic [stma_pkg::COUNT_W-1:0]      count;
        logic                              overflow;
    } t_sum_term;

    logic i_clk = 1'b0;
    logic i_rst_n;

    stma_in_if  in_if ();
    stma_out_if out_if ();

    sparse_triplet_matrix_add u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // pending input items and expected sum terms
    t_in_item  pending_items[$];
    t_sum_term sum_expect[$];

    // predictor state
    stma_pkg::t_term              held_terms[stma_pkg::MAX_TERMS_DEF];
    int                           held_count = 0;
    int                           merge_ptr  = 0;
    logic [stma_pkg::COUNT_W-1:0] out_count  = '0;
    logic                         lost_terms = 1'b0;

    int n_real     = 0;
    int n_queued   = 0;
    int n_accepted = 0;
    int n_results  = 0;
    int n_errors   = 0;

    function automatic void push_sum_term(input logic [stma_pkg::IDX_W-1:0] row,
                                          input logic [stma_pkg::IDX_W-1:0] col,
                                          input logic signed [stma_pkg::SUM_W-1:0] value);
        sum_expect.push_back('{row: row, col: col, value: value, is_end: 1'b0,
                               count: '0, overflow: 1'b0});
        if (out_count < stma_pkg::COUNT_MAX) out_count++;
    endfunction

    // ordered merge of one input item against the stored first-matrix terms
    function automatic void predict_sum(input t_in_item it);
        logic signed [stma_pkg::SUM_W-1:0] a_val;
        logic signed [stma_pkg::SUM_W-1:0] b_val;
        unique case (it.mode)
            stma_pkg::MODE_LOAD: begin
                if (held_count < stma_pkg::MAX_TERMS_DEF) begin
                    held_terms[held_count].row   = it.row;
                    held_terms[held_count].col   = it.col;
                    held_terms[held_count].value = it.value;
                    held_count++;
                end else begin
                    lost_terms = 1'b1;
                end
            end
            stma_pkg::MODE_MERGE: begin
                while (merge_ptr < held_count &&
                       (held_terms[merge_ptr].row < it.row ||
                        (held_terms[merge_ptr].row == it.row &&
                         held_terms[merge_ptr].col < it.col))) begin
                    a_val = held_terms[merge_ptr].value;
                    push_sum_term(held_terms[merge_ptr].row, held_terms[merge_ptr].col, a_val);
                    merge_ptr++;
                end
                b_val = it.value;
                if (merge_ptr < held_count && held_terms[merge_ptr].row == it.row &&
                    held_terms[merge_ptr].col == it.col) begin
                    a_val = held_terms[merge_ptr].value;
                    push_sum_term(it.row, it.col, a_val + b_val);
                    merge_ptr++;
                end else begin
                    push_sum_term(it.row, it.col, b_val);
                end
            end
            stma_pkg::MODE_FINISH: begin
                while (merge_ptr < held_count) begin
                    a_val = held_terms[merge_ptr].value;
                    push_sum_term(held_terms[merge_ptr].row, held_terms[merge_ptr].col, a_val);
                    merge_ptr++;
                end
                sum_expect.push_back('{row: '0, col: '0, value: '0, is_end: 1'b1,
                                       count: out_count, overflow: lost_terms});
                held_count = 0;
                merge_ptr  = 0;
                out_count  = '0;
                lost_terms = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------------
    function automatic void add_item(input logic [stma_pkg::MODE_W-1:0] mode, input int row,
                                     input int col, input logic [stma_pkg::VAL_W-1:0] value);
        t_in_item it;
        it.mode  = mode;
        it.row   = stma_pkg::IDX_W'(row);
        it.col   = stma_pkg::IDX_W'(col);
        it.value = value;
        pending_items.push_back(it);
        if (mode != stma_pkg::MODE_NONE) n_real++;
    endfunction

    function automatic logic [stma_pkg::VAL_W-1:0] pick_value();
        unique case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return stma_pkg::VAL_W'($urandom_range(0, 20)) - 32'd10;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // well-formed pair of sorted term lists sharing some positions
    function automatic void add_matrix_pair(input int pool_n, input int step_max,
                                            input bit a_heavy);
        int a_pos[$];
        int b_pos[$];
        int pos;
        int sel;
        int k;
        pos = $urandom_range(0, step_max - 1);
        for (k = 0; k < pool_n && pos < POS_LIMIT; k++) begin
            sel = a_heavy ? 2 * $urandom_range(0, 1) : $urandom_range(0, 2);
            if (sel != 1) a_pos.push_back(pos);
            if (sel != 0) b_pos.push_back(pos);
            pos += $urandom_range(1, step_max);
        end
        foreach (a_pos[i]) begin
            add_item(stma_pkg::MODE_LOAD, a_pos[i] >> 5, a_pos[i] & 31, pick_value());
            if ($urandom_range(0, 15) == 0)
                add_item(stma_pkg::MODE_NONE, $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom);
        end
        foreach (b_pos[i]) begin
            add_item(stma_pkg::MODE_MERGE, b_pos[i] >> 5, b_pos[i] & 31, pick_value());
            if ($urandom_range(0, 15) == 0)
                add_item(stma_pkg::MODE_NONE, $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom);
        end
        add_item(stma_pkg::MODE_FINISH, $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
    endfunction

    // unsorted lists, duplicates and loads after the merge has begun
    function automatic void add_scrambled();
        int n;
        int k;
        int m;
        bit narrow;
        logic [stma_pkg::MODE_W-1:0] mode;
        n      = $urandom_range(1, 20);
        narrow = $urandom_range(0, 1);
        for (k = 0; k < n; k++) begin
            m = $urandom_range(0, 5);
            mode = (m < 2) ? stma_pkg::MODE_LOAD :
                   (m < 5) ? stma_pkg::MODE_MERGE : stma_pkg::MODE_NONE;
            add_item(mode, narrow ? $urandom_range(0, 3) : $urandom_range(0, 31),
                     narrow ? $urandom_range(0, 3) : $urandom_range(0, 31), pick_value());
        end
        add_item(stma_pkg::MODE_FINISH, $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
    endfunction

    initial begin
        int k;
        int kind;
        in_if.valid      = 1'b0;
        in_if.mode       = stma_pkg::MODE_NONE;
        in_if.term_row   = '0;
        in_if.term_col   = '0;
        in_if.term_value = '0;
        out_if.ready     = 1'b0;
        i_rst_n          = 1'b0;

        // directed part
        add_item(stma_pkg::MODE_NONE, 31, 31, '1);
        add_item(stma_pkg::MODE_FINISH, 0, 0, '0);
        add_item(stma_pkg::MODE_LOAD, 0, 0, 32'h8000_0000);
        add_item(stma_pkg::MODE_LOAD, 0, 5, 32'h7fff_ffff);
        add_item(stma_pkg::MODE_LOAD, 31, 31, '1);
        add_item(stma_pkg::MODE_MERGE, 0, 0, 32'h8000_0000);
        add_item(stma_pkg::MODE_MERGE, 0, 3, 32'd5);
        add_item(stma_pkg::MODE_MERGE, 0, 5, 32'h7fff_ffff);
        add_item(stma_pkg::MODE_MERGE, 31, 31, 32'd1);
        add_item(stma_pkg::MODE_FINISH, 31, 31, '1);
        add_item(stma_pkg::MODE_LOAD, 10, 10, 32'd5);
        add_item(stma_pkg::MODE_LOAD, 20, 0, -32'sd7);
        add_item(stma_pkg::MODE_MERGE, 31, 31, 32'd7);
        add_item(stma_pkg::MODE_LOAD, 31, 31, 32'd3);
        add_item(stma_pkg::MODE_FINISH, 0, 0, '0);
        add_item(stma_pkg::MODE_LOAD, 5, 5, 32'd9);
        add_item(stma_pkg::MODE_MERGE, 5, 5, -32'sd9);
        add_item(stma_pkg::MODE_MERGE, 3, 3, 32'd1);
        add_item(stma_pkg::MODE_FINISH, 0, 0, '0);
        add_item(stma_pkg::MODE_LOAD, 1, 1, 32'd1);
        add_item(stma_pkg::MODE_NONE, 1, 1, 32'd1);
        add_item(stma_pkg::MODE_FINISH, 0, 0, '0);

        // long second matrix so the term count saturates
        add_item(stma_pkg::MODE_LOAD, 0, 1, pick_value());
        add_item(stma_pkg::MODE_LOAD, 2, 2, pick_value());
        for (k = 0; k < 66; k++)
            add_item(stma_pkg::MODE_MERGE, (k * 3) >> 5, (k * 3) & 31, pick_value());
        add_item(stma_pkg::MODE_FINISH, 0, 0, '0);

        while (n_real < TARGET_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind < 6)
                add_matrix_pair($urandom_range(1, 18), $urandom_range(0, 1) ? 3 : 40, 1'b0);
            else if (kind == 6)
                add_matrix_pair($urandom_range(20, 28), 30, 1'b1);
            else
                add_scrambled();
        end
        n_queued = pending_items.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_queued) @(posedge i_clk);
        while (sum_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    function automatic int draw_wait(input bit steady);
        if (steady) return 0;
        return $urandom_range(0, 14);
    endfunction

    // ------------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------------
    t_in_item offered;
    int       send_wait   = 0;
    bit       send_steady = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_sum(offered);
                n_accepted++;
                send_wait = draw_wait(send_steady);
                if ($urandom_range(0, 24) == 0) send_steady = !send_steady;
            end
            // slot is free unless an item is still waiting for ready
            if (!in_if.valid || in_if.ready) begin
                if (send_wait > 0 || pending_items.size() == 0) begin
                    if (send_wait > 0) send_wait--;
                    in_if.valid <= 1'b0;
                end else begin
                    offered = pending_items.pop_front();
                    in_if.valid      <= 1'b1;
                    in_if.mode       <= offered.mode;
                    in_if.term_row   <= offered.row;
                    in_if.term_col   <= offered.col;
                    in_if.term_value <= offered.value;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------------
    t_sum_term want;
    int        recv_wait   = 0;
    int        hold_left   = 0;
    bit        recv_steady = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            recv_wait = 0;
            hold_left = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (sum_expect.size() == 0) begin
                    $error("result item with no expected term pending");
                    n_errors++;
                end else begin
                    want = sum_expect.pop_front();
                    if (out_if.out_row !== want.row) begin
                        $error("out_row: expected %0d, got %0d", want.row, out_if.out_row);
                        n_errors++;
                    end
                    if (out_if.out_col !== want.col) begin
                        $error("out_col: expected %0d, got %0d", want.col, out_if.out_col);
                        n_errors++;
                    end
                    if (out_if.out_value !== want.value) begin
                        $error("out_value: expected %0d, got %0d", want.value,
                               out_if.out_value);
                        n_errors++;
                    end
                    if (out_if.is_end !== want.is_end) begin
                        $error("is_end: expected %0d, got %0d", want.is_end, out_if.is_end);
                        n_errors++;
                    end
                    if (out_if.term_count !== want.count) begin
                        $error("term_count: expected %0d, got %0d", want.count,
                               out_if.term_count);
                        n_errors++;
                    end
                    if (out_if.overflow !== want.overflow) begin
                        $error("overflow: expected %0d, got %0d", want.overflow,
                               out_if.overflow);
                        n_errors++;
                    end
                end
                n_results++;
                // long back-pressure so a pending result holds the block and stalls its input
                if (n_results == 40 || n_results == 250) hold_left = PRESSURE_CYCLES;
                recv_wait = draw_wait(recv_steady);
                if ($urandom_range(0, 24) == 0) recv_steady = !recv_steady;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    int stall_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

endmodule : testbench
